@@ src/cwk_pkg.sv @@
// Package for the CW paddle keyer: keyer phase codes, register indexes,
// the dot length table and the keyer status struct. No dependencies.
`timescale 1ns / 1ps

package cwk_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DOT_ON   = 3'd1,
        PH_DOT_GAP  = 3'd2,
        PH_DASH_ON  = 3'd3,
        PH_DASH_GAP = 3'd4
    } t_phase;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_WPM      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PADDLE_LAYOUT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 8'd2;

    localparam logic [7:0] RESET_DEBOUNCE = 8'd20;
    localparam logic [7:0] RESET_DOT_LEN  = 8'd60;
    localparam int         REM_W          = 10;

    // Dot length in ticks, 1200 / wpm, saturated to 255 (zero wpm also gives 255).
    localparam logic [7:0] DOT_TABLE [0:63] = '{
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd240, 8'd200, 8'd171,
        8'd150, 8'd133, 8'd120, 8'd109, 8'd100, 8'd92,  8'd85,  8'd80,
        8'd75,  8'd70,  8'd66,  8'd63,  8'd60,  8'd57,  8'd54,  8'd52,
        8'd50,  8'd48,  8'd46,  8'd44,  8'd42,  8'd41,  8'd40,  8'd38,
        8'd37,  8'd36,  8'd35,  8'd34,  8'd33,  8'd32,  8'd31,  8'd30,
        8'd30,  8'd29,  8'd28,  8'd27,  8'd27,  8'd26,  8'd26,  8'd25,
        8'd25,  8'd24,  8'd24,  8'd23,  8'd23,  8'd22,  8'd22,  8'd21,
        8'd21,  8'd21,  8'd20,  8'd20,  8'd20,  8'd19,  8'd19,  8'd19
    };

    typedef struct packed {
        logic   key;
        t_phase phase;
    } t_keyer_status;

endpackage

@@ src/cwk_debounce.sv @@
// Debouncer for one raw paddle contact with a saturating hold counter.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module cwk_debounce (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_raw,
    input  logic [7:0] i_debounce_ticks,
    output logic       o_stable_next
);

    logic       r_last;
    logic       r_stable;
    logic [7:0] r_count;
    logic       n_stable;
    logic [7:0] n_count;

    always_comb begin
        if (i_raw != r_last) begin
            n_count = 8'd0;
        end else if (r_count != 8'hFF) begin
            n_count = r_count + 8'd1;
        end else begin
            n_count = r_count;
        end
        n_stable = (n_count >= i_debounce_ticks) ? i_raw : r_stable;
    end

    assign o_stable_next = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b0;
            r_stable <= 1'b0;
            r_count  <= 8'd0;
        end else if (i_step) begin
            r_last   <= i_raw;
            r_stable <= n_stable;
            r_count  <= n_count;
        end
    end

endmodule

@@ src/cwk_fsm.sv @@
// Five-phase element sequencer: dot, dash and inter-element gap timing.
// Depends on cwk_pkg.
`timescale 1ns / 1ps

module cwk_fsm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_dot,
    input  logic                  i_dash,
    input  logic                  i_inhibit,
    input  logic [7:0]            i_dot_length,
    output cwk_pkg::t_keyer_status o_status_next
);

    cwk_pkg::t_phase             r_phase;
    cwk_pkg::t_phase             n_phase;
    logic                        r_key;
    logic                        n_key;
    logic [cwk_pkg::REM_W-1:0]   r_rem;
    logic [cwk_pkg::REM_W-1:0]   n_rem;
    logic [cwk_pkg::REM_W-1:0]   w_rem_dec;
    logic [cwk_pkg::REM_W-1:0]   w_dot_len;
    logic [cwk_pkg::REM_W-1:0]   w_dash_len;
    logic                        w_expired;

    assign w_rem_dec  = (r_rem != '0) ? r_rem - 1'b1 : r_rem;
    assign w_expired  = (w_rem_dec == '0);
    assign w_dot_len  = {2'b00, i_dot_length};
    // Three dots: length plus twice the length, at most 765.
    assign w_dash_len = w_dot_len + {1'b0, i_dot_length, 1'b0};

    always_comb begin
        n_phase = r_phase;
        n_key   = r_key;
        n_rem   = r_rem;
        if (i_inhibit) begin
            n_phase = cwk_pkg::PH_IDLE;
            n_key   = 1'b0;
            n_rem   = '0;
        end else begin
            case (r_phase)
                cwk_pkg::PH_IDLE: begin
                    if (i_dash) begin
                        n_phase = cwk_pkg::PH_DASH_ON;
                        n_key   = 1'b1;
                        n_rem   = w_dash_len;
                    end else if (i_dot) begin
                        n_phase = cwk_pkg::PH_DOT_ON;
                        n_key   = 1'b1;
                        n_rem   = w_dot_len;
                    end
                end
                cwk_pkg::PH_DOT_ON, cwk_pkg::PH_DASH_ON: begin
                    n_rem = w_rem_dec;
                    if (w_expired) begin
                        n_key   = 1'b0;
                        n_phase = (r_phase == cwk_pkg::PH_DOT_ON) ? cwk_pkg::PH_DOT_GAP
                                                                   : cwk_pkg::PH_DASH_GAP;
                        n_rem   = w_dot_len;
                    end
                end
                cwk_pkg::PH_DOT_GAP, cwk_pkg::PH_DASH_GAP: begin
                    n_rem = w_rem_dec;
                    if (w_expired) begin
                        if (i_dash) begin
                            n_phase = cwk_pkg::PH_DASH_ON;
                            n_key   = 1'b1;
                            n_rem   = w_dash_len;
                        end else if (i_dot) begin
                            n_phase = cwk_pkg::PH_DOT_ON;
                            n_key   = 1'b1;
                            n_rem   = w_dot_len;
                        end else begin
                            n_phase = cwk_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = cwk_pkg::PH_IDLE;
                    n_key   = 1'b0;
                    n_rem   = '0;
                end
            endcase
        end
    end

    assign o_status_next.key   = n_key;
    assign o_status_next.phase = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cwk_pkg::PH_IDLE;
            r_key   <= 1'b0;
            r_rem   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_key   <= n_key;
            r_rem   <= n_rem;
        end
    end

endmodule

@@ src/cw_paddle_keyer.sv @@
// CW paddle keyer top level: configuration registers, two debouncers,
// the element sequencer and the result register. Depends on cwk_pkg, cwk_debounce and cwk_fsm.
`timescale 1ns / 1ps

// Usage:
// Feed one item per millisecond tick on the slave stream; tdata carries the raw
// paddle A and B contacts and the inhibit flag. Each accepted item yields exactly
// one result item on the master stream: key line, keyer phase and the debounced
// logical dot and dash paddles, all taken after that tick's update.
// The result is registered and valid in the cycle after acceptance. Throughput is
// one item per cycle while the receiver keeps up: the whole tick update is a single pass
// of logic between the keyer state registers and the result register.
// When the receiver stalls, the result register holds its item and s_tready drops
// until the result is taken; an item is accepted in the same cycle the waiting
// result leaves.
// The configuration channel is always ready. Writing the speed register looks up
// the dot length (1200 / wpm) from a constant table.
// Reset clears the debouncers, puts the keyer idle with the key off, restores
// 20 wpm, right-hand layout and a debounce of 20 ticks, and empties the result register.
module cw_paddle_keyer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Slave stream. tdata: [0] paddle_a_pressed, [1] paddle_b_pressed, [2] inhibit.
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    // Master stream. tdata: [0] key_out, [3:1] keyer_phase, [4] dot_held, [5] dash_held.
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    // Configuration write channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [cwk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_layout;
    logic [7:0] r_debounce;
    logic [7:0] r_dot_length;
    logic       r_out_valid;
    logic [7:0] r_out_data;

    logic       w_step;
    logic       w_cfg_we;
    logic       w_stable_a;
    logic       w_stable_b;
    logic       w_dot;
    logic       w_dash;
    cwk_pkg::t_keyer_status w_status;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_step      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout     <= 1'b0;
            r_debounce   <= cwk_pkg::RESET_DEBOUNCE;
            r_dot_length <= cwk_pkg::RESET_DOT_LEN;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                cwk_pkg::REG_SPEED_WPM:      r_dot_length <= cwk_pkg::DOT_TABLE[i_cfg_data[5:0]];
                cwk_pkg::REG_PADDLE_LAYOUT:  r_layout     <= i_cfg_data[0];
                cwk_pkg::REG_DEBOUNCE_TICKS: r_debounce   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cwk_debounce u_deb_a (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_raw            (i_s_tdata[0]),
        .i_debounce_ticks (r_debounce),
        .o_stable_next    (w_stable_a)
    );

    cwk_debounce u_deb_b (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_raw            (i_s_tdata[1]),
        .i_debounce_ticks (r_debounce),
        .o_stable_next    (w_stable_b)
    );

    // Right-hand layout: paddle A is dash, B is dot; left-hand swaps them.
    assign w_dot  = r_layout ? w_stable_a : w_stable_b;
    assign w_dash = r_layout ? w_stable_b : w_stable_a;

    cwk_fsm u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_dot         (w_dot),
        .i_dash        (w_dash),
        .i_inhibit     (i_s_tdata[2]),
        .i_dot_length  (r_dot_length),
        .o_status_next (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= {2'b00, w_dash, w_dot, w_status.phase, w_status.key};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ src/cwk_checker.sv @@
// Port-level checks for the CW paddle keyer, bound to the top level.
// Depends on cwk_pkg and cw_paddle_keyer.
`timescale 1ns / 1ps

module cwk_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    // The key sounds only during a dot or a dash.
    a_key_only_on_element: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |->
        (o_m_tdata[3:1] == cwk_pkg::PH_DOT_ON || o_m_tdata[3:1] == cwk_pkg::PH_DASH_ON))
        else $error("key high outside an element");

    // An inhibited tick leaves the keyer idle with the key off.
    a_inhibit_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tdata[2]) |=>
        (o_m_tvalid && o_m_tdata[0] == 1'b0 && o_m_tdata[3:1] == cwk_pkg::PH_IDLE))
        else $error("inhibit did not idle the keyer");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind cw_paddle_keyer cwk_checker u_cwk_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ sim/cw_paddle_keyer_test.sv @@
// Self-checking testbench for cw_paddle_keyer: millisecond tick items in, one keyer
// status item out per tick, checked against a cycle-free model of the keyer.
// Depends on cwk_pkg and cw_paddle_keyer.
`timescale 1ns / 1ps

module cw_paddle_keyer_test;

    // Indexes outside the register map; writes to them must change nothing.
    localparam logic [cwk_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 8'd3;
    localparam logic [cwk_pkg::CFG_IDX_W-1:0] REG_UNUSED_MID   = 8'h80;
    localparam logic [cwk_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 8'hFF;

    typedef struct {
        logic            key;
        cwk_pkg::t_phase phase;
        logic            dot;
        logic            dash;
    } t_tick_status;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic [7:0]                    s_tdata   = '0;
    logic                          m_tready  = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [cwk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]                    cfg_data  = '0;
    wire                           s_tready;
    wire                           m_tvalid;
    wire  [7:0]                    m_tdata;
    wire                           cfg_ready;

    // Keyer model state.
    logic [7:0]      dot_ticks;
    logic [7:0]      debounce_len;
    logic            layout_swap;
    logic            raw_last [2];
    logic            settled [2];
    logic [7:0]      hold_cnt [2];
    cwk_pkg::t_phase phase_now;
    logic [9:0]      ticks_left;
    logic            key_now;

    t_tick_status tick_status_q [$];
    int           err_count      = 0;
    int           ticks_sent     = 0;
    int           ticks_reported = 0;
    bit           burst_on       = 1'b0;

    cw_paddle_keyer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] dot_len_for(logic [5:0] wpm);
        int q;
        if (wpm == 6'd0) return 8'd255;
        q = 1200 / int'(wpm);
        return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    function automatic void keyer_reset();
        dot_ticks    = dot_len_for(6'd20);
        debounce_len = cwk_pkg::RESET_DEBOUNCE;
        layout_swap  = 1'b0;
        for (int p = 0; p < 2; p++) begin
            raw_last[p] = 1'b0;
            settled[p]  = 1'b0;
            hold_cnt[p] = 8'd0;
        end
        phase_now  = cwk_pkg::PH_IDLE;
        ticks_left = '0;
        key_now    = 1'b0;
    endfunction

    function automatic void keyer_write(logic [cwk_pkg::CFG_IDX_W-1:0] idx,
                                        logic [7:0] val);
        case (idx)
            cwk_pkg::REG_SPEED_WPM:      dot_ticks = dot_len_for(val[5:0]);
            cwk_pkg::REG_PADDLE_LAYOUT:  layout_swap = val[0];
            cwk_pkg::REG_DEBOUNCE_TICKS: debounce_len = val;
            default: ;
        endcase
    endfunction

    // The hold counter saturates, so a paddle held forever stays settled.
    function automatic void settle_paddle(int p, logic raw);
        if (raw != raw_last[p]) begin
            raw_last[p] = raw;
            hold_cnt[p] = 8'd0;
        end else if (hold_cnt[p] != 8'd255) begin
            hold_cnt[p] = hold_cnt[p] + 8'd1;
        end
        if (hold_cnt[p] >= debounce_len) settled[p] = raw;
    endfunction

    function automatic void start_element(logic dash);
        key_now = 1'b1;
        if (dash) begin
            phase_now  = cwk_pkg::PH_DASH_ON;
            ticks_left = 10'(dot_ticks) * 10'd3;
        end else begin
            phase_now  = cwk_pkg::PH_DOT_ON;
            ticks_left = 10'(dot_ticks);
        end
    endfunction

    function automatic logic count_down();
        if (ticks_left != '0) ticks_left = ticks_left - 10'd1;
        return ticks_left == '0;
    endfunction

    function automatic t_tick_status keyer_tick(logic pad_a, logic pad_b, logic inh);
        t_tick_status st;
        logic         dot;
        logic         dash;
        settle_paddle(0, pad_a);
        settle_paddle(1, pad_b);
        dot  = layout_swap ? settled[0] : settled[1];
        dash = layout_swap ? settled[1] : settled[0];
        if (inh) begin
            key_now    = 1'b0;
            phase_now  = cwk_pkg::PH_IDLE;
            ticks_left = '0;
        end else begin
            case (phase_now)
                cwk_pkg::PH_IDLE: begin
                    if (dash) start_element(1'b1);
                    else if (dot) start_element(1'b0);
                end
                cwk_pkg::PH_DOT_ON, cwk_pkg::PH_DASH_ON: begin
                    if (count_down()) begin
                        key_now    = 1'b0;
                        phase_now  = (phase_now == cwk_pkg::PH_DOT_ON)
                                   ? cwk_pkg::PH_DOT_GAP : cwk_pkg::PH_DASH_GAP;
                        ticks_left = 10'(dot_ticks);
                    end
                end
                cwk_pkg::PH_DOT_GAP, cwk_pkg::PH_DASH_GAP: begin
                    if (count_down()) begin
                        if (dash) start_element(1'b1);
                        else if (dot) start_element(1'b0);
                        else phase_now = cwk_pkg::PH_IDLE;
                    end
                end
                default: begin
                    key_now    = 1'b0;
                    phase_now  = cwk_pkg::PH_IDLE;
                    ticks_left = '0;
                end
            endcase
        end
        st.key   = key_now;
        st.phase = phase_now;
        st.dot   = dot;
        st.dash  = dash;
        return st;
    endfunction

    // Tracks every handshake in edge order, so register writes, ticks and
    // results reach the model in the order the block sees them.
    always @(posedge clk) begin : tick_check
        t_tick_status want;
        if (!rst_n) begin
            keyer_reset();
            tick_status_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) keyer_write(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                tick_status_q.push_back(keyer_tick(s_tdata[0], s_tdata[1], s_tdata[2]));
            if (m_tvalid && m_tready) begin
                if (tick_status_q.size() == 0) begin
                    $error("result item with no tick pending, tdata %h", m_tdata);
                    err_count++;
                end else begin
                    want = tick_status_q.pop_front();
                    if (m_tdata[0] !== want.key) begin
                        $error("key_out: expected %0d, got %0d", want.key, m_tdata[0]);
                        err_count++;
                    end
                    if (m_tdata[3:1] !== 3'(want.phase)) begin
                        $error("keyer_phase: expected %0d, got %0d", want.phase, m_tdata[3:1]);
                        err_count++;
                    end
                    if (m_tdata[4] !== want.dot) begin
                        $error("dot_held: expected %0d, got %0d", want.dot, m_tdata[4]);
                        err_count++;
                    end
                    if (m_tdata[5] !== want.dash) begin
                        $error("dash_held: expected %0d, got %0d", want.dash, m_tdata[5]);
                        err_count++;
                    end
                end
                ticks_reported++;
            end
        end
    end

    // Receiver: mostly ready, short and occasional long stalls, and free-running stretches.
    always @(posedge clk) begin : rx_pace
        int stall_left;
        int free_left;
        int roll;
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (free_left > 0) begin
            free_left = free_left - 1;
            m_tready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                free_left = $urandom_range(20, 200);
                m_tready <= 1'b1;
            end else if (roll < 65) begin
                m_tready <= 1'b1;
            end else if (roll < 95) begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                stall_left = $urandom_range(10, 30);
                m_tready <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Leaves tvalid high on return, so a following call in the same step
    // keeps the stream moving without a bubble.
    task automatic send_tick(input logic pad_a, input logic pad_b, input logic inh);
        int gap;
        gap = burst_on ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, inh, pad_b, pad_a};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (ticks_reported != ticks_sent) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cwk_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic set_keyer(input logic [7:0] wpm, input logic [7:0] layout,
                             input logic [7:0] deb);
        wait_drained();
        write_reg(cwk_pkg::REG_SPEED_WPM, wpm, 1'b0);
        write_reg(cwk_pkg::REG_PADDLE_LAYOUT, layout, 1'b0);
        write_reg(cwk_pkg::REG_DEBOUNCE_TICKS, deb, 1'b1);
    endtask

    // With the reset debounce of 20 ticks nothing settles in a few ticks.
    task automatic test_reset_levels();
        repeat (3) send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
    endtask

    // Zero debounce and an out-of-range speed; dash beats dot, inhibit wins over both,
    // and speed writes land while an element is still running.
    task automatic test_dash_priority();
        set_keyer(8'h3F, 8'h00, 8'h00);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        wait_drained();
        write_reg(cwk_pkg::REG_SPEED_WPM, 8'hC0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        wait_drained();
        write_reg(cwk_pkg::REG_SPEED_WPM, 8'd4, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_layout_swap();
        wait_drained();
        write_reg(cwk_pkg::REG_PADDLE_LAYOUT, 8'hFF, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        wait_drained();
        write_reg(cwk_pkg::REG_PADDLE_LAYOUT, 8'hFE, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_register_decode();
        wait_drained();
        write_reg(REG_UNUSED_FIRST, 8'h00, 1'b0);
        write_reg(REG_UNUSED_LAST, 8'hFF, 1'b0);
        write_reg(REG_UNUSED_MID, 8'h55, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        wait_drained();
        write_reg(cwk_pkg::REG_DEBOUNCE_TICKS, 8'hFF, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
    endtask

    function automatic int pick_hold_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return $urandom_range(1, 4);
        if (roll < 60) return $urandom_range(1, int'(debounce_len) + 4);
        return $urandom_range(int'(debounce_len) + 1,
                              int'(debounce_len) + 4 * int'(dot_ticks));
    endfunction

    // Mostly steady paddle runs long enough to settle and key elements, mixed
    // with contact bounce, inhibit bursts and releases.
    task automatic test_random_keying(input int n_ticks, input bit pause_once);
        int   sent;
        int   len;
        int   kind;
        logic pad_a;
        logic pad_b;
        sent = 0;
        while (sent < n_ticks) begin
            kind     = $urandom_range(0, 99);
            burst_on = ($urandom_range(0, 7) == 0);
            pad_a    = 1'($urandom_range(0, 1));
            pad_b    = 1'($urandom_range(0, 1));
            if (kind < 65) begin
                len = pick_hold_len();
                for (int i = 0; i < len && sent < n_ticks; i++) begin
                    send_tick(pad_a, pad_b, $urandom_range(0, 199) == 0);
                    sent++;
                end
            end else if (kind < 80) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len && sent < n_ticks; i++) begin
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
                    sent++;
                end
            end else if (kind < 90) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len && sent < n_ticks; i++) begin
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
                    sent++;
                end
            end else begin
                len = pick_hold_len();
                for (int i = 0; i < len && sent < n_ticks; i++) begin
                    send_tick(1'b0, 1'b0, 1'b0);
                    sent++;
                end
            end
            if (pause_once && sent >= n_ticks / 2) begin
                wait_drained();
                pause_once = 1'b0;
            end
        end
        burst_on = 1'b0;
    endtask

    initial begin : main_seq
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_levels();
        test_dash_priority();
        test_layout_swap();
        test_register_decode();
        set_keyer(8'd63, 8'd0, 8'd2);
        test_random_keying(250, 1'b1);
        set_keyer(8'd35, 8'd1, 8'd1);
        test_random_keying(250, 1'b0);
        set_keyer(8'd35, 8'd0, 8'd255);
        test_random_keying(200, 1'b0);
        set_keyer(8'd5, 8'd1, 8'd1);
        test_random_keying(350, 1'b1);
        set_keyer(8'd20, 8'd1, 8'd20);
        test_random_keying(200, 1'b0);
        wait_drained();
        repeat (5) @(posedge clk);
        if (err_count == 0 && tick_status_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
